// ===== hdl/lpbt_pkg.sv =====
// Package for the linear-probe binding table: sizes, codes, the slot entry
// type and the control word that runs the ring of slot cells.
// No dependencies; every other file of the block imports it.
package lpbt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 512;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  // Field widths of the command and result words.
  localparam int KIND_W     = 2;
  localparam int CONTEXT_W  = 16;
  localparam int CHANNEL_W  = 5;
  localparam int HASH_W     = 9;
  localparam int INST_W     = 20;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 9;
  localparam int ADDR_W     = 33;
  localparam int STORED_W   = 19;
  localparam int COUNT_W    = 10;
  localparam int BASE_W     = 32;

  // Instance offsets arrive in 16-byte units and are kept in 32-byte units.
  localparam int INSTANCE_SHIFT = 5 - 4;
  // Each table entry takes eight bytes.
  localparam int ENTRY_SHIFT    = 3;

  // Configuration port layout: 32-bit words; the table base register sits at word address 0.
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_TABLE_BASE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_BIND       = 2'd0,
    KIND_UNBIND     = 2'd1,
    KIND_UNBIND_CTX = 2'd2,
    KIND_UNBIND_CHN = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BOUND     = 3'd1,
    ST_BAD_INST  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_DONE
  } state_t;

  // One table slot as held in a cell.
  typedef struct packed {
    logic                 valid;
    logic [CONTEXT_W-1:0] context_id;
    logic [CHANNEL_W-1:0] channel_id;
    logic [STORED_W-1:0]  inst;
  } entry_t;

  // Control from the sequencer to the ring: advance, and the entry that
  // re-enters the far end of the ring in place of the head slot.
  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

endpackage

// ===== hdl/lpbt_cmd_if.sv =====
// Command channel of the binding table: valid/ready handshake and the
// command word fields. Depends on lpbt_pkg.
interface lpbt_cmd_if
  import lpbt_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [CONTEXT_W-1:0] context_id;
  logic [CHANNEL_W-1:0] channel_id;
  logic [HASH_W-1:0]    hash_start;
  logic [INST_W-1:0]    instance_offset;

  modport source (
    output valid, kind, context_id, channel_id, hash_start, instance_offset,
    input  ready
  );
  modport sink (
    input  valid, kind, context_id, channel_id, hash_start, instance_offset,
    output ready
  );
endinterface

// ===== hdl/lpbt_res_if.sv =====
// Result channel of the binding table: valid/ready handshake and the
// result word fields. Depends on lpbt_pkg.
interface lpbt_res_if
  import lpbt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   entry_address;
  logic [STORED_W-1:0] stored_instance;
  logic [COUNT_W-1:0]  cleared_count;

  modport source (
    output valid, status, slot, entry_address, stored_instance, cleared_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot, entry_address, stored_instance, cleared_count,
    output ready
  );
endinterface

// ===== hdl/lpbt_cell.sv =====
// One slot cell of the rotating table ring: holds one entry and loads the
// entry of its neighbor when the ring advances. Depends on lpbt_pkg.
module lpbt_cell
  import lpbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  logic                 valid;
  logic [CONTEXT_W-1:0] context_id;
  logic [CHANNEL_W-1:0] channel_id;
  logic [STORED_W-1:0]  inst;

  // The valid bit is cleared by reset, so the table starts empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  // Payload only matters while the valid bit is set.
  always_ff @(posedge clk) begin
    if (shift) begin
      context_id <= d.context_id;
      channel_id <= d.channel_id;
      inst       <= d.inst;
    end
  end

  assign q = '{valid: valid, context_id: context_id, channel_id: channel_id,
               inst: inst};

endmodule

// ===== hdl/lpbt_ring.sv =====
// Ring of slot cells that holds the whole table. Each advance moves every
// entry one cell toward the head; the written-back head enters the far end.
// Depends on lpbt_pkg and lpbt_cell.
module lpbt_ring
  import lpbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ctl,
  output entry_t    head
);

  entry_t q [TABLE_ENTRIES];

  // Cell i takes from cell i+1; the last cell takes the written-back head.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t d;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign d = ctl.wb;
    end else begin : g_mid
      assign d = q[i+1];
    end
    lpbt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (d),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== hdl/lpbt_ctrl.sv =====
// Sequencer of the binding table: takes a command word, walks the ring once
// (twice for a successful bind), and loads the result word register.
// Depends on lpbt_pkg and the two channel interfaces.
module lpbt_ctrl
  import lpbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lpbt_cmd_if.sink          cmd,
  lpbt_res_if.source        res,
  input  logic [BASE_W-1:0] table_base_addr,
  input  entry_t            head,
  output ring_ctl_t         ring_ctl
);

  state_t state, state_next;

  // Captured command.
  kind_t                kind;
  logic [CONTEXT_W-1:0] ctx;
  logic [CHANNEL_W-1:0] chn;
  logic [IDX_W-1:0]     start;
  logic [STORED_W-1:0]  shifted;

  // Walk position: the slot number of the entry now at the ring head.
  logic [IDX_W-1:0] cnt;
  logic             last;

  // Scan findings.
  logic             dup;
  logic             hi_found, lo_found;
  logic [IDX_W-1:0] hi_slot, lo_slot;
  logic             found;
  logic [IDX_W-1:0] hit_slot;
  logic [STORED_W-1:0] hit_inst;
  logic [CNT_W-1:0] count;

  // Output register.
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [ADDR_W-1:0]   res_addr;
  logic [STORED_W-1:0] res_inst;
  logic [COUNT_W-1:0]  res_count;

  // Per-cycle view of the head entry.
  logic             match, ctx_hit, chn_hit, free_any, bind_ok;
  logic [IDX_W-1:0] target;
  logic             load_res;

  assign last     = (cnt == IDX_W'(TABLE_ENTRIES - 1));
  assign match    = head.valid && head.context_id == ctx && head.channel_id == chn;
  assign ctx_hit  = head.valid && head.context_id == ctx;
  assign chn_hit  = head.valid && head.channel_id == chn;
  assign free_any = hi_found || lo_found;
  assign target   = hi_found ? hi_slot : lo_slot;
  assign bind_ok  = !dup && (shifted != '0) && free_any;

  // Next state, ring control and handshakes.
  always_comb begin
    state_next   = state;
    ring_ctl     = '{shift: 1'b0, wb: head};
    cmd.ready    = 1'b0;
    load_res     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ring_ctl.shift = 1'b1;
        case (kind)
          KIND_UNBIND: begin
            if (match && !found) begin
              ring_ctl.wb.valid = 1'b0;
            end
          end
          KIND_UNBIND_CTX: begin
            if (ctx_hit) begin
              ring_ctl.wb.valid = 1'b0;
            end
          end
          KIND_UNBIND_CHN: begin
            if (chn_hit) begin
              ring_ctl.wb.valid = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (last) begin
          state_next = (kind == KIND_BIND) ? S_DECIDE : S_DONE;
        end
      end
      S_DECIDE: begin
        state_next = bind_ok ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        ring_ctl.shift = 1'b1;
        if (cnt == target) begin
          ring_ctl.wb = '{valid: 1'b1, context_id: ctx, channel_id: chn,
                          inst: shifted};
        end
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || res.ready) begin
          load_res   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
        end
        S_SCAN, S_WRITE: begin
          cnt <= cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      kind     <= kind_t'(cmd.kind);
      ctx      <= cmd.context_id;
      chn      <= cmd.channel_id;
      start    <= IDX_W'(cmd.hash_start);
      shifted  <= STORED_W'(cmd.instance_offset >> INSTANCE_SHIFT);
      dup      <= 1'b0;
      hi_found <= 1'b0;
      lo_found <= 1'b0;
      found    <= 1'b0;
      count    <= '0;
    end else if (state == S_SCAN) begin
      if (match) begin
        dup <= 1'b1;
      end
      // Free slots at or above the start slot come first in probe order.
      if (!head.valid && cnt >= start && !hi_found) begin
        hi_found <= 1'b1;
        hi_slot  <= cnt;
      end
      if (!head.valid && cnt < start && !lo_found) begin
        lo_found <= 1'b1;
        lo_slot  <= cnt;
      end
      // Lowest matching slot for a single unbind.
      if (match && !found) begin
        found    <= 1'b1;
        hit_slot <= cnt;
        hit_inst <= head.inst;
      end
      if ((kind == KIND_UNBIND_CTX && ctx_hit) || (kind == KIND_UNBIND_CHN && chn_hit)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Result word: compose the fields from the scan findings.
  logic                has_slot;
  status_t             r_status;
  logic [IDX_W-1:0]    r_slot;
  logic [STORED_W-1:0] r_inst;
  logic [CNT_W-1:0]    r_count;

  always_comb begin
    has_slot = 1'b0;
    r_status = ST_OK;
    r_slot   = '0;
    r_inst   = '0;
    r_count  = '0;
    case (kind)
      KIND_BIND: begin
        if (dup) begin
          r_status = ST_BOUND;
        end else if (shifted == '0) begin
          r_status = ST_BAD_INST;
        end else if (!free_any) begin
          r_status = ST_FULL;
        end else begin
          has_slot = 1'b1;
          r_slot   = target;
          r_inst   = shifted;
        end
      end
      KIND_UNBIND: begin
        if (found) begin
          has_slot = 1'b1;
          r_slot   = hit_slot;
          r_inst   = hit_inst;
          r_count  = CNT_W'(1);
        end else begin
          r_status = ST_NOT_FOUND;
        end
      end
      default: begin
        r_count = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status <= r_status;
      res_slot   <= SLOT_W'(r_slot);
      res_addr   <= has_slot ? (ADDR_W'(table_base_addr) + (ADDR_W'(r_slot) << ENTRY_SHIFT))
                             : '0;
      res_inst   <= r_inst;
      res_count  <= COUNT_W'(r_count);
    end
  end

  assign res.valid           = res_valid;
  assign res.status          = res_status;
  assign res.slot            = res_slot;
  assign res.entry_address   = res_addr;
  assign res.stored_instance = res_inst;
  assign res.cleared_count   = res_count;

endmodule

// ===== hdl/linear_probe_binding_table.sv =====
// Linear-probe binding table: 512 slots held in a ring of cells that rotates
// one slot per clock, while a command is walked, past a single compare
// point at its head. One command word is worked at a time. Unbind and both
// unbind-all kinds take one full revolution between taking the word and
// loading the result. A bind takes one revolution to check for a duplicate
// and find the first free slot from the start slot, a decision state, and
// on success a second revolution that writes the slot. The result word
// waits in an output register, and the next command word is taken while it
// waits. The table is empty right after reset. table_base_addr is written at
// byte address 0 of the configuration port and only moves entry_address.
// Depends on lpbt_pkg, the channel interfaces, lpbt_ring and lpbt_ctrl.
module linear_probe_binding_table
  import lpbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lpbt_cmd_if.sink           cmd,
  lpbt_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [BASE_W-1:0] table_base_addr;
  logic              reg_sel;
  ring_ctl_t         ring_ctl;
  entry_t            head;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[REG_IDX_LSB] == REG_TABLE_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_addr <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      table_base_addr <= pwdata;
    end
  end

  assign prdata = reg_sel ? table_base_addr : '0;

  // Table storage and sequencer.
  lpbt_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ring_ctl),
    .head (head)
  );

  lpbt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .res             (res),
    .table_base_addr (table_base_addr),
    .head            (head),
    .ring_ctl        (ring_ctl)
  );

endmodule

// ===== hdl/lpbt_checker.sv =====
// Port-level checks of the binding table, attached to the top level by the
// bind statement at the end of this file. Depends on lpbt_pkg.
module lpbt_checker
  import lpbt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic [STATUS_W-1:0] status,
  input logic [SLOT_W-1:0]   slot,
  input logic [ADDR_W-1:0]   entry_address,
  input logic [STORED_W-1:0] stored_instance,
  input logic [COUNT_W-1:0]  cleared_count
);

  // No result word is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word offered right after reset");

  // Once a command word is taken, the block is busy walking the table.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while a walk had just started");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == ST_OK || status == ST_BOUND || status == ST_BAD_INST ||
                   status == ST_FULL || status == ST_NOT_FOUND))
    else $error("undefined status code");

  // A failed command reports no slot and clears nothing.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_OK) |->
      (slot == '0 && entry_address == '0 && stored_instance == '0 && cleared_count == '0))
    else $error("failed command carries slot or count data");

endmodule

bind linear_probe_binding_table lpbt_checker u_lpbt_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .status          (res.status),
  .slot            (res.slot),
  .entry_address   (res.entry_address),
  .stored_instance (res.stored_instance),
  .cleared_count   (res.cleared_count)
);
